FILE: rtl/core/directional_nearest_rect_select_defines.svh
// Assertion macros for the directional nearest rectangle selector.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef DIRECTIONAL_NEAREST_RECT_SELECT_DEFINES_SVH
`define DIRECTIONAL_NEAREST_RECT_SELECT_DEFINES_SVH

`ifndef SYNTHESIS
// Check sampled on the clock, suspended while reset is asserted
`define DNRS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check sampled on the clock, active during reset as well
`define DNRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DNRS_ASSERT(lbl, clk, rstn, prop, msg)
`define DNRS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/core/dnrs_pkg.sv
// Shared types, codes and helpers for the directional nearest rectangle selector.
// No dependencies; imported by every module of the block.
`default_nettype none

package dnrs_pkg;

  // Field widths
  localparam int CoordBits   = 16;
  localparam int IdBits      = 16;
  localparam int WeightBits  = 2 * CoordBits + 4;
  localparam int ApbAddrBits = 5;
  localparam int ApbDataBits = 32;
  localparam int RegIdxBits  = 3;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic        [CoordBits-1:0] ucoord_t;
  typedef logic        [IdBits-1:0]    ident_t;
  typedef logic        [WeightBits-1:0] weight_t;
  typedef logic signed [CoordBits:0]   coord_ext_t;

  // Search direction codes
  localparam logic [1:0] DirLeft  = 2'd0;
  localparam logic [1:0] DirRight = 2'd1;
  localparam logic [1:0] DirUp    = 2'd2;
  localparam logic [1:0] DirDown  = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [RegIdxBits-1:0] RegDirection = 3'd0;
  localparam logic [RegIdxBits-1:0] RegSrcLeft   = 3'd1;
  localparam logic [RegIdxBits-1:0] RegSrcTop    = 3'd2;
  localparam logic [RegIdxBits-1:0] RegSrcRight  = 3'd3;
  localparam logic [RegIdxBits-1:0] RegSrcBottom = 3'd4;

  // Input transfer
  typedef struct packed {
    coord_t cand_left;
    coord_t cand_top;
    coord_t cand_right;
    coord_t cand_bottom;
    ident_t cand_id;
    logic   last_cand;
  } cand_in_t;

  // Output transfer
  typedef struct packed {
    logic   found;
    ident_t best_id;
  } rslt_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  // Per-rectangle geometry flags relative to the source
  typedef struct packed {
    logic is_cand;
    logic toward;
    logic in_beam;
  } geo_flags_t;

  // a - b without overflow
  function automatic coord_ext_t sub_ext(coord_t a, coord_t b);
    return {a[CoordBits-1], a} - {b[CoordBits-1], b};
  endfunction

  // a + b without overflow
  function automatic coord_ext_t sum_ext(coord_t a, coord_t b);
    return {a[CoordBits-1], a} + {b[CoordBits-1], b};
  endfunction

  function automatic logic is_horiz(logic [1:0] dir);
    return (dir == DirLeft) || (dir == DirRight);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dnrs_metric.sv
// Geometry of one rectangle against the source: candidate test, beam, gaps, weight.
// Depends on dnrs_pkg.
`default_nettype none

module dnrs_metric
  import dnrs_pkg::*;
(
  input  logic [1:0] dir_i,
  input  rect_t      src_i,
  input  rect_t      rect_i,
  output geo_flags_t flags_o,
  output ucoord_t    near_o,
  output ucoord_t    far_o,
  output weight_t    weight_o
);

  coord_ext_t                   near_g;
  coord_ext_t                   far_g;
  coord_ext_t                   src_sum;
  coord_ext_t                   rect_sum;
  logic signed [CoordBits+1:0]  cross_diff;
  logic        [CoordBits:0]    cross_abs;
  ucoord_t                      minor;
  logic        [2*CoordBits-1:0] major_sq;
  logic        [2*CoordBits-1:0] minor_sq;
  logic                         horiz;

  assign horiz = is_horiz(dir_i);

  // Direction-specific tests and raw gaps
  always_comb begin
    case (dir_i)
      DirLeft: begin
        flags_o.is_cand = ((src_i.right > rect_i.right) || (src_i.left >= rect_i.right)) &&
                          (src_i.left > rect_i.left);
        flags_o.toward  = src_i.left >= rect_i.right;
        near_g          = sub_ext(src_i.left, rect_i.right);
        far_g           = sub_ext(src_i.left, rect_i.left);
      end
      DirRight: begin
        flags_o.is_cand = ((src_i.left < rect_i.left) || (src_i.right <= rect_i.left)) &&
                          (src_i.right < rect_i.right);
        flags_o.toward  = src_i.right <= rect_i.left;
        near_g          = sub_ext(rect_i.left, src_i.right);
        far_g           = sub_ext(rect_i.right, src_i.right);
      end
      DirUp: begin
        flags_o.is_cand = ((src_i.bottom > rect_i.bottom) || (src_i.top >= rect_i.bottom)) &&
                          (src_i.top > rect_i.top);
        flags_o.toward  = src_i.top >= rect_i.bottom;
        near_g          = sub_ext(src_i.top, rect_i.bottom);
        far_g           = sub_ext(src_i.top, rect_i.top);
      end
      default: begin
        flags_o.is_cand = ((src_i.top < rect_i.top) || (src_i.bottom <= rect_i.top)) &&
                          (src_i.bottom < rect_i.bottom);
        flags_o.toward  = src_i.bottom <= rect_i.top;
        near_g          = sub_ext(rect_i.top, src_i.bottom);
        far_g           = sub_ext(rect_i.bottom, src_i.bottom);
      end
    endcase
    flags_o.in_beam = horiz ?
        ((rect_i.bottom >= src_i.top) && (rect_i.top <= src_i.bottom)) :
        ((rect_i.right >= src_i.left) && (rect_i.left <= src_i.right));
  end

  // Near gap clamps at 0, far gap at 1
  assign near_o = (!near_g[CoordBits] && (near_g != '0)) ? near_g[CoordBits-1:0] : '0;
  assign far_o  = (!far_g[CoordBits] && (far_g[CoordBits:1] != '0)) ?
                  far_g[CoordBits-1:0] : CoordBits'(1);

  // Cross-axis distance between center sums, halved
  assign src_sum    = horiz ? sum_ext(src_i.top, src_i.bottom) : sum_ext(src_i.left, src_i.right);
  assign rect_sum   = horiz ? sum_ext(rect_i.top, rect_i.bottom) :
                              sum_ext(rect_i.left, rect_i.right);
  assign cross_diff = {src_sum[CoordBits], src_sum} - {rect_sum[CoordBits], rect_sum};
  assign cross_abs  = cross_diff[CoordBits+1] ? (CoordBits+1)'(0) - cross_diff[CoordBits:0] :
                                                cross_diff[CoordBits:0];
  assign minor      = cross_abs[CoordBits:1];

  // 13*major^2 + minor^2
  assign major_sq = (2*CoordBits)'(near_o) * (2*CoordBits)'(near_o);
  assign minor_sq = (2*CoordBits)'(minor) * (2*CoordBits)'(minor);
  assign weight_o = (WeightBits'(major_sq) << 3) + (WeightBits'(major_sq) << 2) +
                    WeightBits'(major_sq) + WeightBits'(minor_sq);

endmodule

`default_nettype wire

FILE: rtl/core/dnrs_core.sv
// Kept-best state and the candidate-versus-best decision for one transfer a cycle, taken when fire_i is high.
// Depends on dnrs_pkg and dnrs_metric.
`default_nettype none

module dnrs_core
  import dnrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [1:0] dir_i,
  input  rect_t      src_i,
  input  cand_in_t   cand_i,
  output rslt_t      rslt_o,
  output logic       best_valid_o
);

  rect_t      best_rect_q, best_rect_d;
  ident_t     best_ident_q, best_ident_d;
  logic       best_valid_q, best_valid_d;

  rect_t      cand_rect;
  geo_flags_t c_flags, k_flags;
  ucoord_t    c_near, c_far, k_near, k_far;
  weight_t    c_weight, k_weight;
  logic       c_beam_wins, k_beam_wins, take;
  logic       horiz;

  assign cand_rect = '{left:   cand_i.cand_left,
                       top:    cand_i.cand_top,
                       right:  cand_i.cand_right,
                       bottom: cand_i.cand_bottom};
  assign horiz = is_horiz(dir_i);

  dnrs_metric u_cand_metric (
    .dir_i   (dir_i),
    .src_i   (src_i),
    .rect_i  (cand_rect),
    .flags_o (c_flags),
    .near_o  (c_near),
    .far_o   (c_far),
    .weight_o(c_weight)
  );

  dnrs_metric u_best_metric (
    .dir_i   (dir_i),
    .src_i   (src_i),
    .rect_i  (best_rect_q),
    .flags_o (k_flags),
    .near_o  (k_near),
    .far_o   (k_far),
    .weight_o(k_weight)
  );

  // Beam preference each way; vertical only while near gap stays below the far edge
  assign c_beam_wins = c_flags.in_beam && !k_flags.in_beam &&
                       (!k_flags.toward || horiz || (c_near < k_far));
  assign k_beam_wins = k_flags.in_beam && !c_flags.in_beam &&
                       (!c_flags.toward || horiz || (k_near < c_far));

  // Strict less-than keeps the earlier candidate on ties
  always_comb begin
    if (!c_flags.is_cand) begin
      take = 1'b0;
    end else if (!best_valid_q || !k_flags.is_cand) begin
      take = 1'b1;
    end else if (c_beam_wins) begin
      take = 1'b1;
    end else if (k_beam_wins) begin
      take = 1'b0;
    end else begin
      take = c_weight < k_weight;
    end
  end

  // Next kept best; the last transfer reports and then clears
  always_comb begin
    best_rect_d  = best_rect_q;
    best_ident_d = best_ident_q;
    best_valid_d = best_valid_q;
    if (take) begin
      best_rect_d  = cand_rect;
      best_ident_d = cand_i.cand_id;
      best_valid_d = 1'b1;
    end
    rslt_o.found   = best_valid_d;
    rslt_o.best_id = best_valid_d ? best_ident_d : '0;
    if (cand_i.last_cand) begin
      best_rect_d  = '0;
      best_ident_d = '0;
      best_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_rect_q  <= '0;
      best_ident_q <= '0;
      best_valid_q <= 1'b0;
    end else if (fire_i) begin
      best_rect_q  <= best_rect_d;
      best_ident_q <= best_ident_d;
      best_valid_q <= best_valid_d;
    end
  end

  assign best_valid_o = best_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/directional_nearest_rect_select.sv
// Directional nearest rectangle selector, top level.
// Transfers land in the input register; a last candidate then loads the result register.
// One candidate per cycle; a last candidate waits while a held result is stalled.
// The compare of the registered candidate against the kept best (two 16x16 squarers
// per side) sets the clock period.
// Reset clears the configuration registers, the kept best and both valid flags.
`default_nettype none
`include "directional_nearest_rect_select_defines.svh"

module directional_nearest_rect_select
  import dnrs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Candidate stream
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  cand_in_t               in_data_i,
  // Result stream
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rslt_t                  out_data_o,
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ApbAddrBits-1:0] paddr,
  input  logic [ApbDataBits-1:0] pwdata,
  output logic [ApbDataBits-1:0] prdata,
  output logic                   pready
);

  logic [1:0]            dir_q;
  rect_t                 src_q;
  logic [RegIdxBits-1:0] reg_idx;
  logic                  cfg_wr;

  logic     in_valid_q, in_valid_d;
  cand_in_t in_q;
  logic     out_valid_q, out_valid_d;
  rslt_t    out_q;
  logic     proc_ok, fire, in_take;
  rslt_t    core_rslt;
  logic     best_valid;

  // Configuration registers
  assign reg_idx = paddr[ApbAddrBits-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DirLeft;
      src_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegDirection: dir_q        <= pwdata[1:0];
        RegSrcLeft:   src_q.left   <= pwdata[CoordBits-1:0];
        RegSrcTop:    src_q.top    <= pwdata[CoordBits-1:0];
        RegSrcRight:  src_q.right  <= pwdata[CoordBits-1:0];
        RegSrcBottom: src_q.bottom <= pwdata[CoordBits-1:0];
        default: ;
      endcase
    end
  end

  // Read back, edges sign-extended
  always_comb begin
    case (reg_idx)
      RegDirection: prdata = ApbDataBits'(dir_q);
      RegSrcLeft:   prdata = ApbDataBits'(src_q.left);
      RegSrcTop:    prdata = ApbDataBits'(src_q.top);
      RegSrcRight:  prdata = ApbDataBits'(src_q.right);
      RegSrcBottom: prdata = ApbDataBits'(src_q.bottom);
      default:      prdata = '0;
    endcase
  end

  // Only a last candidate needs room in the output register
  assign proc_ok    = !in_q.last_cand || !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && proc_ok;
  assign in_stall_o = in_valid_q && !proc_ok;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire && in_q.last_cand) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (fire && in_q.last_cand) begin
      out_q <= core_rslt;
    end
  end

  dnrs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .dir_i       (dir_q),
    .src_i       (src_q),
    .cand_i      (in_q),
    .rslt_o      (core_rslt),
    .best_valid_o(best_valid)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `DNRS_ASSERT(a_clear_after_last, clk_i, rst_ni, (fire && in_q.last_cand) |=> !best_valid, "kept best not cleared after last candidate")
  `DNRS_ASSERT(a_none_has_zero_id, clk_i, rst_ni, (out_valid_q && !out_q.found) |-> (out_q.best_id == '0), "result without a find carries a nonzero id")
  `DNRS_ASSERT(a_held_item_kept, clk_i, rst_ni, (in_valid_q && in_stall_o) |=> in_valid_q, "stalled input stage dropped its candidate")
  `DNRS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> (!out_valid_q && !in_valid_q), "valid flags set during reset")

endmodule

`default_nettype wire
